// File: sv/hcs_pkg.sv
// Shared types, register codes and reset values for the harvest cycle sequencer.
package hcs_pkg;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 4;

  localparam logic [15:0] ResetTimeoutS3 = 16'd200;
  localparam logic [15:0] ResetTimeoutS4 = 16'd500;
  localparam logic [15:0] ResetTimeoutS5 = 16'd1000;
  localparam logic [9:0]  ResetNearCm    = 10'd10;
  localparam logic [9:0]  ResetMinCm     = 10'd2;
  localparam logic [15:0] ResetEncMin    = 16'd10;
  localparam logic [15:0] ResetEncDetach = 16'd80;
  localparam logic [7:0]  ResetDutyRun   = 8'd200;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TIMEOUT_S3  = 4'd0,
    CFG_TIMEOUT_S4  = 4'd1,
    CFG_TIMEOUT_S5  = 4'd2,
    CFG_NEAR_DIST   = 4'd3,
    CFG_MIN_VALID   = 4'd4,
    CFG_ENC_MIN     = 4'd5,
    CFG_ENC_DETACH  = 4'd6,
    CFG_DUTY_RUN    = 4'd7
  } cfg_idx_e;

  // S0 idle, S1 armed, S2 approach, S3 grip, S4 motor start, S5 detach,
  // S6 release, S7 fault/return.
  typedef enum logic [7:0] {
    ST_S0 = 8'b0000_0001,
    ST_S1 = 8'b0000_0010,
    ST_S2 = 8'b0000_0100,
    ST_S3 = 8'b0000_1000,
    ST_S4 = 8'b0001_0000,
    ST_S5 = 8'b0010_0000,
    ST_S6 = 8'b0100_0000,
    ST_S7 = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [15:0]        timeout_s3_ms;
    logic [15:0]        timeout_s4_ms;
    logic [15:0]        timeout_s5_ms;
    logic [9:0]         near_distance_cm;
    logic [9:0]         min_valid_cm;
    logic signed [15:0] enc_min_count;
    logic signed [15:0] enc_detach_count;
    logic [7:0]         motor_duty_run;
  } cfg_t;

  typedef struct packed {
    logic [15:0] count;
    logic        armed;
  } tmr_t;

  typedef struct packed {
    logic               start_sw;
    logic               cam_detect;
    logic [9:0]         dist_a_cm;
    logic [9:0]         dist_b_cm;
    logic               stop_1a;
    logic               stop_1b;
    logic               stop_2a;
    logic               stop_2b;
    logic signed [15:0] enc_position;
    logic               ms_tick;
  } in_t;

  typedef struct packed {
    logic [2:0] fsm_code;
    logic       camera_on;
    logic       sol_1a;
    logic       sol_1b;
    logic       sol_2a;
    logic       sol_2b;
    logic [7:0] motor_duty;
    logic       motor_fwd;
    logic       motor_rev;
    logic       enc_clear;
  } out_t;

endpackage

// File: sv/hcs_cfg_regs.sv
// Configuration register file for the harvest cycle sequencer.
module hcs_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hcs_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [hcs_pkg::CfgDataWidth-1:0]  cfg_data_i,
  output hcs_pkg::cfg_t                     cfg_o
);

  hcs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hcs_pkg::cfg_idx_e'(cfg_idx_i))
        hcs_pkg::CFG_TIMEOUT_S3: cfg_d.timeout_s3_ms    = cfg_data_i[15:0];
        hcs_pkg::CFG_TIMEOUT_S4: cfg_d.timeout_s4_ms    = cfg_data_i[15:0];
        hcs_pkg::CFG_TIMEOUT_S5: cfg_d.timeout_s5_ms    = cfg_data_i[15:0];
        hcs_pkg::CFG_NEAR_DIST:  cfg_d.near_distance_cm = cfg_data_i[9:0];
        hcs_pkg::CFG_MIN_VALID:  cfg_d.min_valid_cm     = cfg_data_i[9:0];
        hcs_pkg::CFG_ENC_MIN:    cfg_d.enc_min_count    = $signed(cfg_data_i[15:0]);
        hcs_pkg::CFG_ENC_DETACH: cfg_d.enc_detach_count = $signed(cfg_data_i[15:0]);
        hcs_pkg::CFG_DUTY_RUN:   cfg_d.motor_duty_run   = cfg_data_i[7:0];
        default: ;  // Indexes past the register list are ignored.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_s3_ms    <= hcs_pkg::ResetTimeoutS3;
      cfg_q.timeout_s4_ms    <= hcs_pkg::ResetTimeoutS4;
      cfg_q.timeout_s5_ms    <= hcs_pkg::ResetTimeoutS5;
      cfg_q.near_distance_cm <= hcs_pkg::ResetNearCm;
      cfg_q.min_valid_cm     <= hcs_pkg::ResetMinCm;
      cfg_q.enc_min_count    <= $signed(hcs_pkg::ResetEncMin);
      cfg_q.enc_detach_count <= $signed(hcs_pkg::ResetEncDetach);
      cfg_q.motor_duty_run   <= hcs_pkg::ResetDutyRun;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/hcs_step.sv
// Transition rules, timeout update and actuator decode for one sensor sample.
module hcs_step (
  input  hcs_pkg::state_e  state_i,
  input  hcs_pkg::tmr_t    tmr_i,
  input  hcs_pkg::in_t     smp_i,
  input  hcs_pkg::cfg_t    cfg_i,
  output hcs_pkg::state_e  state_o,
  output hcs_pkg::tmr_t    tmr_o,
  output hcs_pkg::out_t    res_o
);

  logic            tick_inc;
  logic [15:0]     cnt;
  logic            exp_s3, exp_s4, exp_s5;
  logic            near_a, near_b;
  logic            stop1_ok, stop1_back, stop2_ok, stop2_fault;
  logic            running;
  hcs_pkg::state_e nxt;
  hcs_pkg::state_e home;

  always_comb begin
    // The count saturates at all ones and then stays expired.
    tick_inc = tmr_i.armed && smp_i.ms_tick && (tmr_i.count != '1);
    cnt      = tmr_i.count + {15'd0, tick_inc};
    exp_s3   = tmr_i.armed && (cnt >= cfg_i.timeout_s3_ms);
    exp_s4   = tmr_i.armed && (cnt >= cfg_i.timeout_s4_ms);
    exp_s5   = tmr_i.armed && (cnt >= cfg_i.timeout_s5_ms);

    near_a = (smp_i.dist_a_cm <= cfg_i.near_distance_cm) &&
             (smp_i.dist_a_cm >= cfg_i.min_valid_cm);
    near_b = (smp_i.dist_b_cm <= cfg_i.near_distance_cm) &&
             (smp_i.dist_b_cm >= cfg_i.min_valid_cm);

    stop1_ok    = smp_i.stop_1a && !smp_i.stop_1b;
    stop1_back  = smp_i.stop_1b && !smp_i.stop_1a;
    stop2_ok    = smp_i.stop_2a && !smp_i.stop_2b;
    stop2_fault = smp_i.stop_2b && !smp_i.stop_2a;
    home        = smp_i.start_sw ? hcs_pkg::ST_S1 : hcs_pkg::ST_S0;

    nxt = state_i;
    unique case (state_i)
      hcs_pkg::ST_S0: begin
        if (smp_i.start_sw) nxt = hcs_pkg::ST_S1;
      end
      hcs_pkg::ST_S1: begin
        if (!smp_i.start_sw) nxt = hcs_pkg::ST_S0;
        else if (smp_i.cam_detect) nxt = hcs_pkg::ST_S2;
      end
      hcs_pkg::ST_S2: begin
        if (near_a || near_b) nxt = hcs_pkg::ST_S3;
        else if (stop2_fault) nxt = hcs_pkg::ST_S7;
      end
      hcs_pkg::ST_S3: begin
        if (stop1_ok || exp_s3) nxt = hcs_pkg::ST_S4;
      end
      hcs_pkg::ST_S4: begin
        if (smp_i.enc_position >= cfg_i.enc_min_count) nxt = hcs_pkg::ST_S5;
        else if (exp_s4) nxt = hcs_pkg::ST_S7;
      end
      hcs_pkg::ST_S5: begin
        if (stop2_ok && (smp_i.enc_position > cfg_i.enc_detach_count)) begin
          nxt = hcs_pkg::ST_S6;
        end else if (exp_s5) begin
          nxt = hcs_pkg::ST_S7;
        end
      end
      hcs_pkg::ST_S6: begin
        if (stop2_ok && stop1_back) nxt = home;
      end
      hcs_pkg::ST_S7: begin
        if (stop2_ok) nxt = home;
      end
      default: nxt = hcs_pkg::ST_S0;
    endcase

    // Entering a state rearms the one-shot only for grip, motor start and detach.
    if (nxt != state_i) begin
      tmr_o.count = '0;
      tmr_o.armed = (nxt == hcs_pkg::ST_S3) || (nxt == hcs_pkg::ST_S4) ||
                    (nxt == hcs_pkg::ST_S5);
    end else begin
      tmr_o.count = cnt;
      tmr_o.armed = tmr_i.armed;
    end
    state_o = nxt;

    res_o = '0;
    unique case (nxt)
      hcs_pkg::ST_S0: res_o.fsm_code = 3'd0;
      hcs_pkg::ST_S1: begin
        res_o.fsm_code  = 3'd1;
        res_o.camera_on = 1'b1;
        res_o.sol_1b    = 1'b1;
        res_o.sol_2b    = 1'b1;
      end
      hcs_pkg::ST_S2: begin
        res_o.fsm_code  = 3'd2;
        res_o.camera_on = 1'b1;
        res_o.sol_1b    = 1'b1;
        res_o.sol_2a    = 1'b1;
      end
      hcs_pkg::ST_S3: begin
        res_o.fsm_code = 3'd3;
        res_o.sol_1a   = 1'b1;
        res_o.sol_2a   = 1'b1;
      end
      hcs_pkg::ST_S4: begin
        res_o.fsm_code = 3'd4;
        res_o.sol_1a   = 1'b1;
        res_o.sol_1b   = 1'b1;
        res_o.sol_2a   = 1'b1;
      end
      hcs_pkg::ST_S5: begin
        res_o.fsm_code = 3'd5;
        res_o.sol_1a   = 1'b1;
        res_o.sol_1b   = 1'b1;
        res_o.sol_2b   = 1'b1;
      end
      hcs_pkg::ST_S6: begin
        res_o.fsm_code  = 3'd6;
        res_o.camera_on = 1'b1;
        res_o.sol_1b    = 1'b1;
        res_o.sol_2b    = 1'b1;
      end
      hcs_pkg::ST_S7: begin
        res_o.fsm_code = 3'd7;
        res_o.sol_1b   = 1'b1;
        res_o.sol_2b   = 1'b1;
      end
      default: res_o.fsm_code = 3'd0;
    endcase

    // The motor runs forward in motor start and detach; the encoder is held
    // in clear everywhere else.
    running          = (nxt == hcs_pkg::ST_S4) || (nxt == hcs_pkg::ST_S5);
    res_o.motor_duty = running ? cfg_i.motor_duty_run : 8'd0;
    res_o.motor_fwd  = running;
    res_o.motor_rev  = 1'b0;
    res_o.enc_clear  = !running;
  end

endmodule

// File: sv/harvest_cycle_sequencer.sv
// Top level of the harvest cycle sequencer: sample register, state, and result register.
// Each accepted sensor sample yields exactly one result: the state reached and the
// actuator drive decoded from it. A sample is captured into an input register, then
// the transition rules and the millisecond timeout of grip, motor start and detach
// are evaluated in shallow combinational logic that updates the state and loads the
// result register. One sample is taken every cycle unless the result side stalls.
// Input and output are parted by the result register, so a new request is accepted
// while an earlier result still waits to be taken. Configuration registers are
// written through a simple write port and should only be changed while no request
// is in flight.
module harvest_cycle_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hcs_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hcs_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [hcs_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [hcs_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  hcs_pkg::cfg_t   cfg;
  hcs_pkg::in_t    smp_q;
  logic            smp_vld_q;
  hcs_pkg::state_e state_q, state_d;
  hcs_pkg::tmr_t   tmr_q, tmr_d;
  hcs_pkg::out_t   res_q, res_d;
  logic            res_vld_q;
  logic            advance;

  hcs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hcs_step u_step (
    .state_i (state_q),
    .tmr_i   (tmr_q),
    .smp_i   (smp_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .tmr_o   (tmr_d),
    .res_o   (res_d)
  );

  // A held sample moves on when the result register is free or being emptied.
  assign advance    = smp_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !smp_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= hcs_pkg::ST_S0;
      tmr_q     <= '0;
    end else begin
      if (in_ready_o) begin
        smp_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
        tmr_q     <= tmr_d;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

// File: dv/harvest_cycle_sequencer_tb.sv
// Self-checking testbench for the harvest cycle sequencer: directed walks, timeouts, random cycles.
module harvest_cycle_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ARMED, PH_APPROACH, PH_GRIP, PH_MOTOR_START, PH_DETACH, PH_RELEASE, PH_FAULT
  } phase_e;

  localparam logic [hcs_pkg::CfgIdxWidth-1:0] CfgIdxFirstUnused = 4'd8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hcs_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hcs_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [hcs_pkg::CfgIdxWidth-1:0] cfg_idx = '0;
  logic [hcs_pkg::CfgDataWidth-1:0] cfg_data = '0;

  // Predicted sequencer state and its copy of the registers.
  phase_e phase = PH_IDLE;
  logic [15:0] tmr_count = '0;
  logic tmr_armed = 1'b0;
  logic [15:0] tmo_grip = hcs_pkg::ResetTimeoutS3;
  logic [15:0] tmo_start = hcs_pkg::ResetTimeoutS4;
  logic [15:0] tmo_detach = hcs_pkg::ResetTimeoutS5;
  logic [9:0] near_cm = hcs_pkg::ResetNearCm;
  logic [9:0] min_cm = hcs_pkg::ResetMinCm;
  logic signed [15:0] enc_min = hcs_pkg::ResetEncMin;
  logic signed [15:0] enc_detach = hcs_pkg::ResetEncDetach;
  logic [7:0] duty_run = hcs_pkg::ResetDutyRun;

  hcs_pkg::out_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned max_gap = 12;
  int unsigned max_stall = 12;

  harvest_cycle_sequencer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic in_window(logic [9:0] d);
    return d <= near_cm && d >= min_cm;
  endfunction

  // Applies one sensor sample to the predicted state and returns the actuator drive.
  function automatic hcs_pkg::out_t advance_sequencer(hcs_pkg::in_t s);
    phase_e nxt;
    logic [15:0] lim;
    logic timed_out;
    logic stop2_ok;
    logic [5:0] drive;
    hcs_pkg::out_t r;
    nxt = phase;
    lim = '1;
    stop2_ok = s.stop_2a && !s.stop_2b;
    if (tmr_armed && s.ms_tick && tmr_count != 16'hFFFF) tmr_count++;
    case (phase)
      PH_GRIP: lim = tmo_grip;
      PH_MOTOR_START: lim = tmo_start;
      PH_DETACH: lim = tmo_detach;
      default: lim = '1;
    endcase
    timed_out = tmr_armed && (phase inside {PH_GRIP, PH_MOTOR_START, PH_DETACH}) &&
                tmr_count >= lim;
    case (phase)
      PH_IDLE: if (s.start_sw) nxt = PH_ARMED;
      PH_ARMED: begin
        if (!s.start_sw) nxt = PH_IDLE;
        else if (s.cam_detect) nxt = PH_APPROACH;
      end
      PH_APPROACH: begin
        if (in_window(s.dist_a_cm) || in_window(s.dist_b_cm)) nxt = PH_GRIP;
        else if (s.stop_2b && !s.stop_2a) nxt = PH_FAULT;
      end
      PH_GRIP: if ((s.stop_1a && !s.stop_1b) || timed_out) nxt = PH_MOTOR_START;
      PH_MOTOR_START: begin
        if ($signed(s.enc_position) >= enc_min) nxt = PH_DETACH;
        else if (timed_out) nxt = PH_FAULT;
      end
      PH_DETACH: begin
        if (stop2_ok && $signed(s.enc_position) > enc_detach) nxt = PH_RELEASE;
        else if (timed_out) nxt = PH_FAULT;
      end
      PH_RELEASE: begin
        if (stop2_ok && s.stop_1b && !s.stop_1a) nxt = s.start_sw ? PH_ARMED : PH_IDLE;
      end
      default: if (stop2_ok) nxt = s.start_sw ? PH_ARMED : PH_IDLE;
    endcase
    if (nxt != phase) begin
      tmr_count = '0;
      tmr_armed = nxt inside {PH_GRIP, PH_MOTOR_START, PH_DETACH};
    end
    phase = nxt;
    // Bits: camera, sol_1a, sol_1b, sol_2a, sol_2b, motor running.
    case (nxt)
      PH_IDLE: drive = 6'b000000;
      PH_ARMED: drive = 6'b101010;
      PH_APPROACH: drive = 6'b101100;
      PH_GRIP: drive = 6'b010100;
      PH_MOTOR_START: drive = 6'b011101;
      PH_DETACH: drive = 6'b011011;
      PH_RELEASE: drive = 6'b101010;
      default: drive = 6'b001010;
    endcase
    r.fsm_code = nxt;
    r.camera_on = drive[5];
    r.sol_1a = drive[4];
    r.sol_1b = drive[3];
    r.sol_2a = drive[2];
    r.sol_2b = drive[1];
    r.motor_duty = drive[0] ? duty_run : 8'd0;
    r.motor_fwd = drive[0];
    r.motor_rev = 1'b0;
    r.enc_clear = !drive[0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_sample(hcs_pkg::in_t s);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(advance_sequencer(s));
  endtask

  task automatic write_reg(logic [hcs_pkg::CfgIdxWidth-1:0] idx,
                           logic [hcs_pkg::CfgDataWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      hcs_pkg::CFG_TIMEOUT_S3: tmo_grip = value;
      hcs_pkg::CFG_TIMEOUT_S4: tmo_start = value;
      hcs_pkg::CFG_TIMEOUT_S5: tmo_detach = value;
      hcs_pkg::CFG_NEAR_DIST: near_cm = value[9:0];
      hcs_pkg::CFG_MIN_VALID: min_cm = value[9:0];
      hcs_pkg::CFG_ENC_MIN: enc_min = value;
      hcs_pkg::CFG_ENC_DETACH: enc_detach = value;
      hcs_pkg::CFG_DUTY_RUN: duty_run = value[7:0];
      default: ;
    endcase
  endtask

  // Stops sending and waits for every pending result.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // From idle, walks through armed and approach into grip.
  task automatic enter_grip();
    hcs_pkg::in_t s;
    s = '0;
    s.start_sw = 1'b1;
    send_sample(s);
    s.cam_detect = 1'b1;
    send_sample(s);
    s.dist_a_cm = near_cm;
    send_sample(s);
  endtask

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(9, 0))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(15, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_enc();
    case ($urandom_range(5, 0))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom_range(200, 0)) - 16'd100;
    endcase
  endfunction

  // Random sensor sample, mostly steered toward the next step of a harvest cycle.
  function automatic hcs_pkg::in_t field_sample();
    hcs_pkg::in_t s;
    logic [63:0] raw;
    logic [9:0] hit;
    raw = {$urandom, $urandom};
    s = raw[$bits(hcs_pkg::in_t)-1:0];
    if ($urandom_range(9, 0) < 7) begin
      case (phase)
        PH_IDLE: s.start_sw = 1'b1;
        PH_ARMED: begin
          s.start_sw = 1'b1;
          s.cam_detect = 1'b1;
        end
        PH_APPROACH: begin
          if ($urandom_range(3, 0) == 0) begin
            // Both readings outside the window where the window allows it, with the fault pattern on the far stops.
            if (min_cm > 0) begin
              s.dist_a_cm = '0;
              s.dist_b_cm = '0;
            end else if (near_cm != 10'h3FF) begin
              s.dist_a_cm = 10'h3FF;
              s.dist_b_cm = 10'h3FF;
            end
            s.stop_2b = 1'b1;
            s.stop_2a = 1'b0;
          end else if (min_cm <= near_cm) begin
            hit = 10'($urandom_range(near_cm, min_cm));
            if ($urandom_range(1, 0)) s.dist_a_cm = hit;
            else s.dist_b_cm = hit;
          end
        end
        PH_GRIP: begin
          if ($urandom_range(1, 0)) begin
            s.stop_1a = 1'b0;
            s.ms_tick = 1'b1;
          end else begin
            s.stop_1a = 1'b1;
            s.stop_1b = 1'b0;
          end
        end
        PH_MOTOR_START: begin
          if ($urandom_range(1, 0)) begin
            s.enc_position = enc_min + 16'($urandom_range(3, 0));
          end else begin
            s.enc_position = enc_min - 16'($urandom_range(4, 1));
            s.ms_tick = 1'b1;
          end
        end
        PH_DETACH: begin
          if ($urandom_range(1, 0)) begin
            s.stop_2a = 1'b1;
            s.stop_2b = 1'b0;
            s.enc_position = enc_detach + 16'($urandom_range(4, 1));
          end else begin
            s.ms_tick = 1'b1;
          end
        end
        PH_RELEASE: begin
          s.stop_2a = 1'b1;
          s.stop_2b = 1'b0;
          s.stop_1b = 1'b1;
          s.stop_1a = 1'b0;
        end
        default: begin
          s.stop_2a = 1'b1;
          s.stop_2b = 1'b0;
        end
      endcase
    end
    return s;
  endfunction

  // One full cycle through every state, with held and advancing steps, at the reset register values.
  task automatic test_directed_walk();
    hcs_pkg::in_t s;
    s = '0;
    s.ms_tick = 1'b1;
    send_sample(s);
    s.start_sw = 1'b1;
    send_sample(s);
    s.start_sw = 1'b0;
    send_sample(s);
    s.start_sw = 1'b1;
    send_sample(s);
    send_sample(s);
    s.cam_detect = 1'b1;
    send_sample(s);
    s = '0;
    s.dist_a_cm = 10'd1;
    s.dist_b_cm = 10'd11;
    s.stop_2a = 1'b1;
    s.stop_2b = 1'b1;
    send_sample(s);
    s.dist_a_cm = 10'h3FF;
    s.dist_b_cm = 10'd2;
    send_sample(s);
    s = '0;
    s.stop_1a = 1'b1;
    s.stop_1b = 1'b1;
    send_sample(s);
    s.stop_1b = 1'b0;
    send_sample(s);
    s = '0;
    s.enc_position = 16'sd9;
    send_sample(s);
    s.enc_position = 16'sh8000;
    send_sample(s);
    s.enc_position = 16'sd10;
    send_sample(s);
    s = '0;
    s.stop_2a = 1'b1;
    s.enc_position = 16'sd80;
    send_sample(s);
    s.stop_2b = 1'b1;
    s.enc_position = 16'sd81;
    send_sample(s);
    s.stop_2b = 1'b0;
    s.enc_position = 16'sh7FFF;
    send_sample(s);
    s = '0;
    s.stop_2a = 1'b1;
    s.stop_1b = 1'b1;
    s.stop_1a = 1'b1;
    send_sample(s);
    s.stop_1a = 1'b0;
    s.start_sw = 1'b1;
    send_sample(s);
    s = '0;
    s.start_sw = 1'b1;
    s.cam_detect = 1'b1;
    send_sample(s);
    s = '0;
    s.stop_2b = 1'b1;
    send_sample(s);
    s.stop_2a = 1'b1;
    send_sample(s);
    s.stop_2b = 1'b0;
    send_sample(s);
  endtask

  // Zero timeout in grip, counted expiry in motor start and detach.
  task automatic test_timeouts();
    hcs_pkg::in_t s;
    settle();
    write_reg(hcs_pkg::CFG_TIMEOUT_S3, 16'd0);
    write_reg(hcs_pkg::CFG_TIMEOUT_S4, 16'd3);
    write_reg(hcs_pkg::CFG_TIMEOUT_S5, 16'd1);
    enter_grip();
    s = '0;
    send_sample(s);
    s.ms_tick = 1'b1;
    send_sample(s);
    send_sample(s);
    s.ms_tick = 1'b0;
    send_sample(s);
    s.ms_tick = 1'b1;
    send_sample(s);
    s = '0;
    s.stop_2a = 1'b1;
    send_sample(s);
    enter_grip();
    s = '0;
    send_sample(s);
    s.enc_position = enc_min;
    send_sample(s);
    s = '0;
    send_sample(s);
    s.ms_tick = 1'b1;
    send_sample(s);
    s = '0;
    s.stop_2a = 1'b1;
    send_sample(s);
  endtask

  // Grip at the largest timeout register value holds through a run of ticks, sent back to back.
  task automatic test_long_grip_timeout();
    hcs_pkg::in_t s;
    settle();
    max_gap = 0;
    max_stall = 0;
    write_reg(hcs_pkg::CFG_TIMEOUT_S3, 16'hFFFF);
    enter_grip();
    s = '0;
    s.ms_tick = 1'b1;
    repeat (20) send_sample(s);
    s = '0;
    s.stop_1a = 1'b1;
    send_sample(s);
    s = '0;
    s.enc_position = 16'sh7FFF;
    send_sample(s);
    s.stop_2a = 1'b1;
    send_sample(s);
    s = '0;
    s.stop_2a = 1'b1;
    s.stop_1b = 1'b1;
    send_sample(s);
    max_gap = 12;
    max_stall = 12;
  endtask

  task automatic test_random_cycles();
    for (int blk = 0; blk < 12; blk++) begin
      settle();
      write_reg(hcs_pkg::CFG_TIMEOUT_S3, pick_timeout());
      write_reg(hcs_pkg::CFG_TIMEOUT_S4, pick_timeout());
      write_reg(hcs_pkg::CFG_TIMEOUT_S5, pick_timeout());
      // Upper data bits above a register's width carry junk and must be dropped.
      case ($urandom_range(3, 0))
        0: write_reg(hcs_pkg::CFG_NEAR_DIST, {6'($urandom), 10'h3FF});
        1: write_reg(hcs_pkg::CFG_NEAR_DIST, {6'($urandom), 10'h000});
        default: write_reg(hcs_pkg::CFG_NEAR_DIST, 16'($urandom));
      endcase
      case ($urandom_range(3, 0))
        0: write_reg(hcs_pkg::CFG_MIN_VALID, {6'($urandom), 10'h000});
        1: write_reg(hcs_pkg::CFG_MIN_VALID, {6'($urandom), 10'h3FF});
        default: write_reg(hcs_pkg::CFG_MIN_VALID, {6'($urandom), 10'($urandom_range(20, 0))});
      endcase
      write_reg(hcs_pkg::CFG_ENC_MIN, pick_enc());
      write_reg(hcs_pkg::CFG_ENC_DETACH, pick_enc());
      case ($urandom_range(2, 0))
        0: write_reg(hcs_pkg::CFG_DUTY_RUN, {8'($urandom), 8'h00});
        1: write_reg(hcs_pkg::CFG_DUTY_RUN, {8'($urandom), 8'hFF});
        default: write_reg(hcs_pkg::CFG_DUTY_RUN, 16'($urandom));
      endcase
      write_reg(CfgIdxFirstUnused + 4'($urandom_range(7, 0)), 16'($urandom));
      case (blk % 3)
        0: begin
          max_gap = 12;
          max_stall = 12;
        end
        1: begin
          max_gap = 0;
          max_stall = 0;
        end
        default: begin
          max_gap = 2;
          max_stall = 12;
        end
      endcase
      repeat (100) send_sample(field_sample());
    end
  endtask

  // Result side: random stall before each result is taken, then compare with the oldest prediction.
  initial begin
    int unsigned stall;
    hcs_pkg::out_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(max_stall, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_data), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.fsm_code !== want.fsm_code)
          report_mismatch("fsm_code", 32'(out_data.fsm_code), 32'(want.fsm_code));
        if (out_data.camera_on !== want.camera_on)
          report_mismatch("camera_on", 32'(out_data.camera_on), 32'(want.camera_on));
        if (out_data.sol_1a !== want.sol_1a)
          report_mismatch("sol_1a", 32'(out_data.sol_1a), 32'(want.sol_1a));
        if (out_data.sol_1b !== want.sol_1b)
          report_mismatch("sol_1b", 32'(out_data.sol_1b), 32'(want.sol_1b));
        if (out_data.sol_2a !== want.sol_2a)
          report_mismatch("sol_2a", 32'(out_data.sol_2a), 32'(want.sol_2a));
        if (out_data.sol_2b !== want.sol_2b)
          report_mismatch("sol_2b", 32'(out_data.sol_2b), 32'(want.sol_2b));
        if (out_data.motor_duty !== want.motor_duty)
          report_mismatch("motor_duty", 32'(out_data.motor_duty), 32'(want.motor_duty));
        if (out_data.motor_fwd !== want.motor_fwd)
          report_mismatch("motor_fwd", 32'(out_data.motor_fwd), 32'(want.motor_fwd));
        if (out_data.motor_rev !== want.motor_rev)
          report_mismatch("motor_rev", 32'(out_data.motor_rev), 32'(want.motor_rev));
        if (out_data.enc_clear !== want.enc_clear)
          report_mismatch("enc_clear", 32'(out_data.enc_clear), 32'(want.enc_clear));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_walk();
    test_timeouts();
    test_long_grip_timeout();
    test_random_cycles();
    settle();
    if (expected_results.size() != 0)
      report_mismatch("results still pending at end", 32'(expected_results.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
sv/hcs_pkg.sv
sv/hcs_cfg_regs.sv
sv/hcs_step.sv
sv/harvest_cycle_sequencer.sv
dv/harvest_cycle_sequencer_tb.sv
